/* sv/assert_macros.svh */
// Assertion macros shared by the RTL. Synthesis builds define SYNTH so that
// every check drops out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("%m: check failed");
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* sv/bf3_pkg.sv */
`default_nettype none
package bf3_pkg;

   localparam int DEFAULT_MAX_WIDTH = 256;
   localparam int RESET_WIDTH       = 256;
   localparam int RESET_HEIGHT      = 256;
   localparam int HEIGHT_LIMIT      = 4096;
   localparam int MIN_DIM           = 2;

   localparam int WIDTH_FIELD_W = 9;
   localparam int HEIGHT_W      = 13;
   localparam int ROW_W         = 13;
   localparam int CSR_DATA_W    = 13;
   localparam int CSR_INDEX_W   = 1;
   localparam int PIXEL_W       = 8;
   localparam int COLSUM_W      = 10;
   localparam int SUM_W         = 12;
   localparam int SUM_MAX       = 2295;

   // floor(x / 9) == (x * 7282) >> 16 for every x up to SUM_MAX.
   localparam int RECIP_NINE  = 7282;
   localparam int RECIP_W     = 13;
   localparam int RECIP_SHIFT = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   typedef struct packed {
      logic               kind;
      logic [PIXEL_W-1:0] pixel_in;
   } req_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_out;
      logic               frame_last;
   } rsp_type;

endpackage
`default_nettype wire

/* sv/box_filter_3x3_replicate.sv */
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_ready   req_data  (kind, pixel_in)
// rsp      out        rsp_valid/rsp_ready   rsp_data  (pixel_out, frame_last)
// csr      in         csr_valid/csr_ready   csr_index, csr_wdata
//
// One beat per cycle unless rsp stalls; rsp_valid rises as a result leaves stage two.
// Line memories are read as a beat is taken, written as a non-last beat leaves stage one.
// Reset restores 256 x 256 geometry and the frame start; memories need no clear.
// With rsp stalled, beats that give a result fill stage two and then stage one,
// after which req_ready falls.
`default_nettype none
`include "assert_macros.svh"
module box_filter_3x3_replicate #(
   parameter int MAX_WIDTH = bf3_pkg::DEFAULT_MAX_WIDTH
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire bf3_pkg::req_type                   req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output bf3_pkg::rsp_type                        rsp_data,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [bf3_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [bf3_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int WID_W = $clog2(MAX_WIDTH + 1);
   localparam int WIDTH_AT_RESET =
      (bf3_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : bf3_pkg::RESET_WIDTH;
   localparam int PROD_W = bf3_pkg::SUM_W + bf3_pkg::RECIP_W;

   typedef struct packed {
      logic [COL_W-1:0]            col;
      logic [bf3_pkg::PIXEL_W-1:0] pix;
      logic                        row0;
      logic                        use_mem;
      logic                        do_a;
      logic                        do_b;
      logic                        col_one;
      logic                        last;
   } s1_type;

   // Geometry and input position.
   logic [WID_W-1:0]             width_ff, width_in;
   logic [bf3_pkg::HEIGHT_W-1:0] height_ff, height_in;
   logic [COL_W-1:0]             col_ff, col_in;
   logic [bf3_pkg::ROW_W-1:0]    row_ff, row_in;

   logic [bf3_pkg::WIDTH_FIELD_W-1:0] wr_width;
   logic [bf3_pkg::HEIGHT_W-1:0]      wr_height;
   logic                              csr_write;

   logic   req_accept, in_frame, ignore_beat, col_wrap;
   s1_type s1_in, s1_ff;
   logic   s1_valid_ff, s1_en, s1_fire;

   logic [bf3_pkg::PIXEL_W-1:0]  up_rd, mid_rd, value, up_px, mid_px;
   logic [bf3_pkg::COLSUM_W-1:0] c1_ff, c2_ff, new_total;
   logic [bf3_pkg::SUM_W-1:0]    sum;
   logic                         wr_en;

   logic                      s2_valid_ff, s2_en, s2_last_ff;
   logic [bf3_pkg::SUM_W-1:0] s2_sum_ff;
   logic [PROD_W-1:0]         product;

   logic             rsp_valid_ff, out_en;
   bf3_pkg::rsp_type rsp_data_ff;

   // ---------------------------------------------------------------- csr
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign wr_width  = csr_wdata[bf3_pkg::WIDTH_FIELD_W-1:0];
   assign wr_height = csr_wdata[bf3_pkg::HEIGHT_W-1:0];

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         case (csr_index)
            bf3_pkg::CSR_IMAGE_WIDTH: begin
               if (32'(wr_width) < bf3_pkg::MIN_DIM) begin
                  width_in = WID_W'(bf3_pkg::MIN_DIM);
               end else if (32'(wr_width) > MAX_WIDTH) begin
                  width_in = WID_W'(MAX_WIDTH);
               end else begin
                  width_in = WID_W'(wr_width);
               end
            end
            bf3_pkg::CSR_IMAGE_HEIGHT: begin
               if (32'(wr_height) < bf3_pkg::MIN_DIM) begin
                  height_in = bf3_pkg::HEIGHT_W'(bf3_pkg::MIN_DIM);
               end else if (32'(wr_height) > bf3_pkg::HEIGHT_LIMIT) begin
                  height_in = bf3_pkg::HEIGHT_W'(bf3_pkg::HEIGHT_LIMIT);
               end else begin
                  height_in = wr_height;
               end
            end
            default: begin
               width_in  = width_ff;
               height_in = height_ff;
            end
         endcase
      end
   end

   // ------------------------------------------------------- accept decode
   assign req_accept  = req_valid && req_ready;
   assign in_frame    = row_ff < height_ff;
   // A flush before the last pixel of the frame has arrived changes nothing.
   assign ignore_beat = in_frame && (req_data.kind == bf3_pkg::KIND_FLUSH);
   assign col_wrap    = (WID_W'(col_ff) + WID_W'(1)) >= width_ff;

   always_comb begin
      s1_in.col     = col_ff;
      s1_in.pix     = req_data.pixel_in;
      s1_in.row0    = row_ff == '0;
      s1_in.use_mem = !in_frame;
      s1_in.do_a    = (col_ff == '0) && (row_ff >= bf3_pkg::ROW_W'(2));
      s1_in.last    = s1_in.do_a &&
                      (row_ff == (height_ff + bf3_pkg::HEIGHT_W'(1)));
      s1_in.do_b    = (col_ff != '0) && (row_ff != '0);
      s1_in.col_one = col_ff == COL_W'(1);
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_write) begin
         col_in = '0;
         row_in = '0;
      end else if (req_accept && !ignore_beat) begin
         if (s1_in.last) begin
            col_in = '0;
            row_in = '0;
         end else if (col_wrap) begin
            col_in = '0;
            row_in = row_ff + bf3_pkg::ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   // ------------------------------------------------------ line memories
   bf3_ram #(
      .WIDTH (bf3_pkg::PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_upper (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_ff.col),
      .wr_data (mid_px),
      .rd_en   (req_accept),
      .rd_addr (col_ff),
      .rd_data (up_rd)
   );

   bf3_ram #(
      .WIDTH (bf3_pkg::PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_middle (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_ff.col),
      .wr_data (value),
      .rd_en   (req_accept),
      .rd_addr (col_ff),
      .rd_data (mid_rd)
   );

   // --------------------------------------------------------- stage one
   // Below the last row the bottom row is repeated from the middle store.
   assign value     = s1_ff.use_mem ? mid_rd : s1_ff.pix;
   assign up_px     = s1_ff.row0 ? value : up_rd;
   assign mid_px    = s1_ff.row0 ? value : mid_rd;
   assign new_total = bf3_pkg::COLSUM_W'(up_px) + bf3_pkg::COLSUM_W'(mid_px)
                      + bf3_pkg::COLSUM_W'(value);

   // The end-of-row result repeats the rightmost column; the second column
   // of a row repeats the leftmost one.
   always_comb begin
      if (s1_ff.do_a) begin
         sum = bf3_pkg::SUM_W'(c1_ff) + bf3_pkg::SUM_W'({c2_ff, 1'b0});
      end else begin
         sum = bf3_pkg::SUM_W'(s1_ff.col_one ? c2_ff : c1_ff)
               + bf3_pkg::SUM_W'(c2_ff) + bf3_pkg::SUM_W'(new_total);
      end
   end

   assign s1_en   = !s1_valid_ff || s2_en;
   assign s1_fire = s1_valid_ff && s2_en;
   assign wr_en   = s1_fire && !s1_ff.last;
   assign req_ready = s1_en;

   // --------------------------------------------------------- stage two
   assign s2_en   = !s2_valid_ff || out_en;
   assign product = PROD_W'(s2_sum_ff) * PROD_W'(bf3_pkg::RECIP_NINE);

   // ------------------------------------------------------------- output
   assign out_en    = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WID_W'(WIDTH_AT_RESET);
         height_ff    <= bf3_pkg::HEIGHT_W'(bf3_pkg::RESET_HEIGHT);
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         if (s1_en) begin
            s1_valid_ff <= req_accept && !ignore_beat;
         end
         if (s2_en) begin
            s2_valid_ff <= s1_fire && (s1_ff.do_a || s1_ff.do_b);
         end
         if (out_en) begin
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_ff <= s1_in;
      end
      if (wr_en) begin
         c1_ff <= c2_ff;
         c2_ff <= new_total;
      end
      if (s2_en) begin
         s2_sum_ff  <= sum;
         s2_last_ff <= s1_ff.last;
      end
      if (out_en) begin
         rsp_data_ff.pixel_out  <= product[bf3_pkg::RECIP_SHIFT +: bf3_pkg::PIXEL_W];
         rsp_data_ff.frame_last <= s2_last_ff;
      end
   end

   // ---------------------------------------------------------- checks
   `ASSERT_IMPLY(a_no_same_entry, clock, reset, wr_en && req_accept, s1_ff.col != col_ff)
   `ASSERT_ALWAYS(a_col_in_row, clock, reset, WID_W'(col_ff) < width_ff)
   `ASSERT_IMPLY(a_sum_bound, clock, reset, s2_valid_ff, 32'(s2_sum_ff) <= bf3_pkg::SUM_MAX)
   `ASSERT_NEXT(a_frame_restart, clock, reset, req_accept && !ignore_beat && s1_in.last, (row_ff == '0) && (col_ff == '0))
   `ASSERT_IMPLY(a_last_no_write, clock, reset, s1_valid_ff && s1_ff.last, !wr_en)

endmodule
`default_nettype wire

/* sv/bf3_ram.sv */
`default_nettype none
module bf3_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* dv/box_filter_3x3_replicate_tb.sv */
`timescale 1ns / 100ps
module box_filter_3x3_replicate_tb;

   localparam int NEIGHBOURS = 9;

   typedef enum int {SHADE_NOISE, SHADE_EXTREME, SHADE_WHITE, SHADE_BLACK} shade_type;

   // Tracks the filter's geometry, line stores and window, and keeps the means
   // still owed by the block in arrival order.
   class mean_board_type;
      int unsigned width, height, col, row, errors;
      logic [bf3_pkg::PIXEL_W-1:0] upper_line [bf3_pkg::DEFAULT_MAX_WIDTH];
      logic [bf3_pkg::PIXEL_W-1:0] middle_line [bf3_pkg::DEFAULT_MAX_WIDTH];
      logic [bf3_pkg::PIXEL_W-1:0] win [3][3];
      bf3_pkg::rsp_type pending_means[$];

      function new();
         width = bf3_pkg::RESET_WIDTH;
         height = bf3_pkg::RESET_HEIGHT;
         col = 0;
         row = 0;
         errors = 0;
         foreach (upper_line[k]) begin
            upper_line[k] = '0;
            middle_line[k] = '0;
         end
         foreach (win[a, b]) win[a][b] = '0;
      endfunction

      function void configure(logic [bf3_pkg::CSR_INDEX_W-1:0] index,
                              logic [bf3_pkg::CSR_DATA_W-1:0] data);
         int unsigned v, top;
         if (index == bf3_pkg::CSR_IMAGE_WIDTH) begin
            v = data[bf3_pkg::WIDTH_FIELD_W-1:0];
            top = bf3_pkg::DEFAULT_MAX_WIDTH;
         end else begin
            v = data;
            top = bf3_pkg::HEIGHT_LIMIT;
         end
         if (v < bf3_pkg::MIN_DIM) v = bf3_pkg::MIN_DIM;
         if (v > top) v = top;
         if (index == bf3_pkg::CSR_IMAGE_WIDTH) width = v;
         else height = v;
         col = 0;
         row = 0;
      endfunction

      function int unsigned column_sum(int s);
         return int'(win[s][0]) + int'(win[s][1]) + int'(win[s][2]);
      endfunction

      function void take_beat(bf3_pkg::req_type beat);
         logic [bf3_pkg::PIXEL_W-1:0] value, up, mid;
         int unsigned j, left, total;
         bf3_pkg::rsp_type mean;
         j = col;
         if (row < height) begin
            if (beat.kind == bf3_pkg::KIND_FLUSH) return;
            value = beat.pixel_in;
         end else begin
            // Below the frame the bottom row is repeated.
            value = middle_line[j];
         end
         if (j == 0 && row >= 2) begin
            // The window still holds the last column of the row two up, which
            // serves as its own right-hand neighbour.
            total = column_sum(1) + 2 * column_sum(2);
            mean.pixel_out = bf3_pkg::PIXEL_W'(total / NEIGHBOURS);
            mean.frame_last = (row == height + 1);
            pending_means.push_back(mean);
            if (mean.frame_last) begin
               col = 0;
               row = 0;
               return;
            end
         end
         if (row == 0) begin
            up = value;
            mid = value;
         end else begin
            up = upper_line[j];
            mid = middle_line[j];
         end
         upper_line[j] = mid;
         middle_line[j] = value;
         for (int k = 0; k < 3; k++) begin
            win[0][k] = win[1][k];
            win[1][k] = win[2][k];
         end
         win[2][0] = up;
         win[2][1] = mid;
         win[2][2] = value;
         if (j >= 1 && row >= 1) begin
            left = (j == 1) ? column_sum(1) : column_sum(0);
            total = left + column_sum(1) + column_sum(2);
            mean.pixel_out = bf3_pkg::PIXEL_W'(total / NEIGHBOURS);
            mean.frame_last = 1'b0;
            pending_means.push_back(mean);
         end
         if (j + 1 >= width) begin
            col = 0;
            row++;
         end else begin
            col = j + 1;
         end
      endfunction

      function void check_mean(bf3_pkg::rsp_type got);
         bf3_pkg::rsp_type want;
         if (pending_means.size() == 0) begin
            $error("unexpected result: pixel_out %0d frame_last %0b",
                   got.pixel_out, got.frame_last);
            errors++;
            return;
         end
         want = pending_means.pop_front();
         if (got.pixel_out !== want.pixel_out) begin
            $error("pixel_out: expected %0d, actual %0d", want.pixel_out, got.pixel_out);
            errors++;
         end
         if (got.frame_last !== want.frame_last) begin
            $error("frame_last: expected %0b, actual %0b", want.frame_last, got.frame_last);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   bf3_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   bf3_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [bf3_pkg::CSR_INDEX_W-1:0] csr_index = bf3_pkg::CSR_IMAGE_WIDTH;
   logic [bf3_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   bit steady_req = 1'b0;
   bit steady_rsp = 1'b0;
   int rsp_wait = 0;
   int beats_sent = 0;
   mean_board_type board;

   box_filter_3x3_replicate dut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #15_000_000;
      $display("box_filter_3x3_replicate: mismatch");
      $finish;
   end

   // Result side: every accepted beat is checked, then ready is held low for a
   // freshly drawn number of cycles.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            board.check_mean(rsp_data);
            rsp_wait = steady_rsp ? 0 : $urandom_range(0, 9);
         end
         if (rsp_wait > 0) begin
            rsp_ready <= 1'b0;
            rsp_wait--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_beat(logic kind, logic [bf3_pkg::PIXEL_W-1:0] level);
      int gap;
      bf3_pkg::req_type beat;
      gap = steady_req ? 0 : $urandom_range(0, 9);
      beat.kind = kind;
      beat.pixel_in = level;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (!req_ready);
      board.take_beat(beat);
      beats_sent++;
   endtask

   // Waits for every owed mean, then lets the pipeline drain of beats that
   // produce nothing.
   task automatic settle();
      req_valid <= 1'b0;
      while (board.pending_means.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_beat(logic [bf3_pkg::CSR_INDEX_W-1:0] index,
                           logic [bf3_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      board.configure(index, data);
   endtask

   task automatic reconfigure(bit set_width, logic [bf3_pkg::CSR_DATA_W-1:0] width_data,
                              bit set_height, logic [bf3_pkg::CSR_DATA_W-1:0] height_data);
      settle();
      if (set_width) csr_beat(bf3_pkg::CSR_IMAGE_WIDTH, width_data);
      if (set_height) csr_beat(bf3_pkg::CSR_IMAGE_HEIGHT, height_data);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [bf3_pkg::PIXEL_W-1:0] shade(shade_type s);
      case (s)
         SHADE_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
         SHADE_WHITE: return 8'hFF;
         SHADE_BLACK: return 8'h00;
         default: return 8'($urandom);
      endcase
   endfunction

   // One whole frame: pixels with stray early flushes mixed in, then the
   // flush run, some of whose beats are pixels that the block treats as flushes.
   task automatic run_frame(shade_type s, int noise_pct, int stray_pct);
      int unsigned w, h;
      w = board.width;
      h = board.height;
      for (int p = 0; p < w * h; p++) begin
         if ($urandom_range(1, 100) <= noise_pct) begin
            send_beat(bf3_pkg::KIND_FLUSH, 8'($urandom));
         end
         send_beat(bf3_pkg::KIND_PIXEL, shade(s));
      end
      for (int f = 0; f <= w; f++) begin
         if ($urandom_range(1, 100) <= stray_pct) send_beat(bf3_pkg::KIND_PIXEL, 8'($urandom));
         else send_beat(bf3_pkg::KIND_FLUSH, 8'($urandom));
      end
   endtask

   initial begin
      int pick;
      bit [1:0] choice;
      shade_type s;
      board = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Smallest frame, saturated to 2 x 2 from below; full scale, then 0/255 extremes.
      reconfigure(1'b1, 13'h0000, 1'b1, 13'h0001);
      run_frame(SHADE_WHITE, 0, 0);
      run_frame(SHADE_EXTREME, 50, 50);

      // Upper width bits are masked off; the frame is abandoned part way through
      // and restarted by the next register write.
      reconfigure(1'b1, 13'h1E03, 1'b0, '0);
      repeat (4) send_beat(bf3_pkg::KIND_PIXEL, 8'($urandom));
      reconfigure(1'b0, '0, 1'b1, 13'h0000);
      run_frame(SHADE_BLACK, 0, 0);

      // Largest width: both rows go in and the first flushes bring out the end-of-row
      // mean over the rightmost columns before the frame is abandoned.
      reconfigure(1'b1, 13'h1FFF, 1'b1, 13'h0002);
      repeat (2 * board.width) send_beat(bf3_pkg::KIND_PIXEL, shade(SHADE_NOISE));
      repeat (2) send_beat(bf3_pkg::KIND_FLUSH, 8'($urandom));

      // Largest height on the narrowest frame; a few rows are sent, then abandoned.
      reconfigure(1'b1, 13'h0002, 1'b1, 13'h1FFF);
      repeat (40) send_beat(bf3_pkg::KIND_PIXEL, shade(SHADE_NOISE));

      while (beats_sent < 800) begin
         choice = 2'($urandom_range(0, 3));
         pick = $urandom_range(0, 5);
         s = (pick > 3) ? SHADE_NOISE : shade_type'(pick);
         if (choice != 2'b00) begin
            reconfigure(choice[0], {4'($urandom), 9'($urandom_range(2, 12))},
                        choice[1], 13'($urandom_range(0, 6)));
         end
         steady_req = ($urandom_range(0, 4) == 0);
         steady_rsp = ($urandom_range(0, 4) == 0);
         run_frame(s, $urandom_range(0, 15), $urandom_range(0, 30));
      end

      settle();
      if (board.errors == 0 && board.pending_means.size() == 0) begin
         $display("box_filter_3x3_replicate: match");
      end else begin
         $display("box_filter_3x3_replicate: mismatch");
      end
      $finish;
   end
endmodule
